/* hdl/point_transform_perspective_assert.svh */
// assertion macros for the point transform block
// used by the top level only; needs nothing else
`ifndef POINT_TRANSFORM_PERSPECTIVE_ASSERT_SVH
`define POINT_TRANSFORM_PERSPECTIVE_ASSERT_SVH

// same-cycle implication, held off during reset
`define PTP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ptp assertion failed");

// next-cycle implication, held off during reset
`define PTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ptp assertion failed");

`endif

/* hdl/ptp_pkg.sv */
// shared types and constants of the point transform block
// no dependencies
package ptp_pkg;

  localparam int IO_W         = 32;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_NUM_REGS = 8;
  localparam int CFG_SEL_W    = 3;
  localparam int CFG_IDX_W    = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_FIRST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW4_SECOND = 4'd7;

  // reset matrix is the identity in Q16.16
  localparam logic [CFG_DATA_W-1:0] CFG_RESET [CFG_NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef struct packed {
    logic [IO_W-1:0] in_x;
    logic [IO_W-1:0] in_y;
    logic [IO_W-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic [IO_W-1:0] out_x;
    logic [IO_W-1:0] out_y;
    logic [IO_W-1:0] out_z;
    logic            w_zero;
    logic            saturated;
  } out_item_t;

  // flags that travel with one divider lane
  typedef struct packed {
    logic big;
    logic neg;
    logic zero;
  } div_flags_t;

endpackage

/* hdl/ptp_stream_if.sv */
// valid/ready stream channel with a typed payload
// payload types come from ptp_pkg
interface ptp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/point_transform_perspective.sv */
// point transform with perspective divide, top level
// throughput: one point per cycle; a multiply stage, three adder stages and
// one divider stage per quotient bit, all stalled together by the output register
// reset: matrix returns to the identity, pipeline valid bits and output valid clear
module point_transform_perspective #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ptp_stream_if.sink                      in_i,
  ptp_stream_if.source                    out_o
);
  import ptp_pkg::*;

  localparam int CW       = COORD_WIDTH;
  localparam int PW       = (2 * CW > CW + FRAC_BITS + 1) ? 2 * CW : CW + FRAC_BITS + 1;
  localparam int MAG_W    = PW + 1;
  localparam int QB       = CW + 1;
  localparam int MAC_LAT  = 4;
  localparam int PIPE_LAT = MAC_LAT + QB + 1;
  localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (CW - 1));
  localparam logic signed [CW-1:0] MAX_S = CW'(LIM_POS);
  localparam logic signed [CW-1:0] MIN_S = CW'(LIM_NEG);

  logic [CFG_DATA_W-1:0] cfg_q [CFG_NUM_REGS];
  logic signed [CW-1:0]  mat   [4][4];
  logic signed [CW-1:0]  pt    [3];
  logic [MAG_W-1:0]      mag   [4];
  logic [3:0]            neg;
  logic                  adv;
  logic [PIPE_LAT-1:0]   vld_q;
  logic                  w_zero;
  logic [QB-1:0]         quo   [3];
  div_flags_t            flg   [3];
  logic signed [CW-1:0]  res   [3];
  logic [2:0]            sat;
  out_item_t             out_d;
  out_item_t             out_q;
  logic                  out_valid_q;

  // matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM_REGS; i++) begin
        cfg_q[i] <= CFG_RESET[i];
      end
    end else if (cfg_we_i && cfg_idx_i >= REG_ROW1_FIRST && cfg_idx_i <= REG_ROW4_SECOND) begin
      cfg_q[cfg_idx_i[CFG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // entry extraction: low CW bits of each half, signed
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign mat[r][c] = $signed(cfg_q[2 * r + c / 2][(c % 2) * 32 +: CW]);
    end
  end

  assign pt[0] = $signed(in_i.data.in_x[CW-1:0]);
  assign pt[1] = $signed(in_i.data.in_y[CW-1:0]);
  assign pt[2] = $signed(in_i.data.in_z[CW-1:0]);

  // whole pipeline moves when the output register is free or being taken
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  ptp_mac #(.CW(CW), .F(FRAC_BITS), .PW(PW), .MAG_W(MAG_W)) u_mac (
    .clk_i (clk_i),
    .adv_i (adv),
    .pt_i  (pt),
    .mat_i (mat),
    .mag_o (mag),
    .neg_o (neg)
  );

  assign w_zero = mag[3] == '0;

  // three divider lanes share the w column
  for (genvar c = 0; c < 3; c++) begin : g_lane
    ptp_div #(.MAG_W(MAG_W), .F(FRAC_BITS), .QB(QB)) u_div (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .num_i   (mag[c]),
      .den_i   (mag[3]),
      .flags_i ('{big: 1'b0, neg: neg[c] ^ neg[3], zero: w_zero}),
      .q_o     (quo[c]),
      .flags_o (flg[c])
    );
  end

  // valid bits travel alongside the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_i.valid};
    end
  end

  // clamp and sign
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (flg[c].neg) begin
        sat[c] = flg[c].big || (quo[c] > LIM_NEG);
        res[c] = sat[c] ? MIN_S : CW'(-quo[c]);
      end else begin
        sat[c] = flg[c].big || (quo[c] > LIM_POS);
        res[c] = sat[c] ? MAX_S : CW'(quo[c]);
      end
    end
    if (flg[0].zero) begin
      out_d = '{out_x: '0, out_y: '0, out_z: '0, w_zero: 1'b1, saturated: 1'b0};
    end else begin
      out_d = '{out_x: IO_W'(res[0]), out_y: IO_W'(res[1]), out_z: IO_W'(res[2]),
                w_zero: 1'b0, saturated: |sat};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`include "point_transform_perspective_assert.svh"

  // zero w gives zero outputs and no clamp
  `PTP_ASSERT_IMPL(a_wzero_clean, clk_i, rst_ni, out_valid_q && out_q.w_zero, out_q.out_x == '0 && out_q.out_y == '0 && out_q.out_z == '0 && !out_q.saturated)
  // a stall freezes the valid bits of every stage
  `PTP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !adv, $stable(vld_q) && out_valid_q)
  // an accepted point enters the first stage
  `PTP_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_i.valid && adv, vld_q[0])

endmodule

/* hdl/ptp_mac.sv */
// matrix multiply-accumulate pipeline: four column sums as sign and magnitude
// four register stages; depends on nothing outside the module
module ptp_mac #(
  parameter int CW    = 32,
  parameter int F     = 16,
  parameter int PW    = 64,
  parameter int MAG_W = 65
) (
  input  logic                  clk_i,
  input  logic                  adv_i,
  input  logic signed [CW-1:0]  pt_i  [3],
  input  logic signed [CW-1:0]  mat_i [4][4],
  output logic [MAG_W-1:0]      mag_o [4],
  output logic [3:0]            neg_o
);
  localparam int ACC_W = PW + 2;

  logic signed [2*CW-1:0]  mul     [4][3];
  logic signed [PW-1:0]    prod_q  [4][4];
  logic signed [ACC_W-1:0] pair_q  [4][2];
  logic signed [ACC_W-1:0] sum_q   [4];
  logic [ACC_W-1:0]        nsum    [4];
  logic [MAG_W-1:0]        mag_q   [4];
  logic [3:0]              neg_q;

  // one multiplier per entry of the first three matrix rows; the fourth row is shifted by F
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        mul[c][r] = pt_i[r] * mat_i[r][c];
      end
      nsum[c] = -sum_q[c];
    end
  end

  // products, pair sums, column sum, magnitude
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[c][r] <= PW'(mul[c][r]);
        end
        prod_q[c][3] <= PW'(mat_i[3][c]) <<< F;
        pair_q[c][0] <= ACC_W'(prod_q[c][0]) + ACC_W'(prod_q[c][1]);
        pair_q[c][1] <= ACC_W'(prod_q[c][2]) + ACC_W'(prod_q[c][3]);
        sum_q[c]     <= pair_q[c][0] + pair_q[c][1];
        neg_q[c]     <= sum_q[c][ACC_W-1];
        mag_q[c]     <= sum_q[c][ACC_W-1] ? nsum[c][MAG_W-1:0]
                                          : sum_q[c][MAG_W-1:0];
      end
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;
endmodule

/* hdl/ptp_div.sv */
// pipelined restoring divider lane: floor(num * 2^F / den), QB quotient bits
// one quotient bit per stage after a range check; uses ptp_pkg flags
module ptp_div #(
  parameter int MAG_W = 65,
  parameter int F     = 16,
  parameter int QB    = 33
) (
  input  logic                   clk_i,
  input  logic                   adv_i,
  input  logic [MAG_W-1:0]       num_i,
  input  logic [MAG_W-1:0]       den_i,
  input  ptp_pkg::div_flags_t    flags_i,
  output logic [QB-1:0]          q_o,
  output ptp_pkg::div_flags_t    flags_o
);
  import ptp_pkg::*;

  localparam int NW = MAG_W + F;

  logic [NW-1:0]    numer;
  logic [NW-1:0]    hi;
  logic             big0;
  logic [MAG_W-1:0] rem_q [QB];
  logic [QB-1:0]    low_q [QB];
  logic [MAG_W-1:0] den_q [QB];
  logic [QB-1:0]    quo_q [QB+1];
  div_flags_t       flg_q [QB+1];

  // range check: quotient of 2^QB or more is out of reach
  always_comb begin
    numer = {num_i, {F{1'b0}}};
    hi    = numer >> QB;
    big0  = hi >= NW'(den_i);
  end

  // setup stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= hi[MAG_W-1:0];
      low_q[0] <= numer[QB-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      flg_q[0] <= '{big: big0, neg: flags_i.neg, zero: flags_i.zero};
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           ge;

    always_comb begin
      trial = {rem_q[k], low_q[k][QB-1]};
      diff  = trial - {1'b0, den_q[k]};
      ge    = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quo_q[k+1] <= {quo_q[k][QB-2:0], ge};
        flg_q[k+1] <= flg_q[k];
      end
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          low_q[k+1] <= {low_q[k][QB-2:0], 1'b0};
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign q_o     = quo_q[QB];
  assign flags_o = flg_q[QB];
endmodule

/* dv/tb_point_transform_perspective.sv */
// testbench for point_transform_perspective: 4x4 matrix transform and perspective divide
// depends on ptp_pkg, ptp_stream_if and the block itself
module tb_point_transform_perspective;
  import ptp_pkg::*;

  // matrix register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_SECOND = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_FIRST  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_SECOND = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_FIRST  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_SECOND = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW4_FIRST  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 4'd15;
  localparam int LATENCY = 40;

  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ptp_stream_if #(.payload_t(in_item_t))  pt_in ();
  ptp_stream_if #(.payload_t(out_item_t)) pt_out ();

  point_transform_perspective dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(pt_in.sink), .out_o(pt_out.source)
  );

  // model copy of the matrix registers and pending projected points
  logic [CFG_DATA_W-1:0] matrix_copy [CFG_NUM_REGS];
  out_item_t projected_q [$];
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int n_errors = 0;
  int n_points = 0;
  int n_wzero = 0;
  int n_sat = 0;
  int n_cfg = 0;

  initial begin
    pt_in.valid = 1'b0;
    pt_in.data = '0;
    pt_out.ready = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    pt_out.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic logic signed [127:0] entry(int r, int c);
    logic [63:0] rv;
    logic [31:0] half;
    rv = matrix_copy[r * 2 + c / 2];
    half = (c % 2) ? rv[63:32] : rv[31:0];
    entry = $signed(half);
  endfunction

  // row vector (x, y, z, 1) times matrix, then divide by w with saturation
  function automatic out_item_t project_point(in_item_t p);
    logic signed [127:0] px, py, pz;
    logic signed [127:0] col [4];
    logic [127:0] wmag, nmag, quo;
    logic [31:0] res [3];
    logic neg, sat;
    out_item_t o;
    px = $signed(p.in_x);
    py = $signed(p.in_y);
    pz = $signed(p.in_z);
    sat = 1'b0;
    for (int c = 0; c < 4; c++) begin
      col[c] = px * entry(0, c) + py * entry(1, c) + pz * entry(2, c) + (entry(3, c) <<< 16);
    end
    if (col[3] == 0) begin
      o = '0;
      o.w_zero = 1'b1;
      return o;
    end
    wmag = col[3] < 0 ? -col[3] : col[3];
    for (int c = 0; c < 3; c++) begin
      nmag = col[c] < 0 ? -col[c] : col[c];
      neg = (col[c] < 0) != (col[3] < 0);
      quo = (nmag << 16) / wmag;
      if (neg) begin
        if (quo > 128'h8000_0000) begin
          quo = 128'h8000_0000;
          sat = 1'b1;
        end
        res[c] = -quo[31:0];
      end else begin
        if (quo > 128'h7FFF_FFFF) begin
          quo = 128'h7FFF_FFFF;
          sat = 1'b1;
        end
        res[c] = quo[31:0];
      end
    end
    o.out_x = res[0];
    o.out_y = res[1];
    o.out_z = res[2];
    o.w_zero = 1'b0;
    o.saturated = sat;
    return o;
  endfunction

  // check each result transfer against the oldest projection
  always @(posedge clk_i) begin
    if (rst_ni && pt_out.valid && pt_out.ready) begin
      out_item_t got, want;
      got = pt_out.data;
      if (projected_q.size() == 0) begin
        $error("unexpected result transfer: %h", got);
        n_errors++;
      end else begin
        want = projected_q.pop_front();
        if (got.out_x !== want.out_x) begin
          $error("out_x expected %h actual %h", want.out_x, got.out_x);
          n_errors++;
        end
        if (got.out_y !== want.out_y) begin
          $error("out_y expected %h actual %h", want.out_y, got.out_y);
          n_errors++;
        end
        if (got.out_z !== want.out_z) begin
          $error("out_z expected %h actual %h", want.out_z, got.out_z);
          n_errors++;
        end
        if (got.w_zero !== want.w_zero) begin
          $error("w_zero expected %b actual %b", want.w_zero, got.w_zero);
          n_errors++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, got.saturated);
          n_errors++;
        end
        n_wzero += want.w_zero;
        n_sat += want.saturated;
      end
    end
  end

  // send one point, idling at random first
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t p;
    p.in_x = x;
    p.in_y = y;
    p.in_z = z;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      pt_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pt_in.valid <= 1'b1;
    pt_in.data <= p;
    do @(posedge clk_i); while (!pt_in.ready);
    projected_q.push_back(project_point(p));
    n_points++;
  endtask

  // let the pipeline empty before touching registers
  task automatic drain();
    @(negedge clk_i);
    pt_in.valid <= 1'b0;
    wait (projected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx < CFG_NUM_REGS) matrix_copy[idx] = val;
    n_cfg++;
  endtask

  task automatic write_matrix(logic [63:0] m [CFG_NUM_REGS]);
    drain();
    for (int i = 0; i < CFG_NUM_REGS; i++) write_reg(i[CFG_IDX_W-1:0], m[i]);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: rand_coord = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      1: rand_coord = $urandom;
      2: begin
        case ($urandom_range(4))
          0: rand_coord = Q_MAX;
          1: rand_coord = Q_MIN;
          2: rand_coord = Q_ONE;
          3: rand_coord = Q_NEG_ONE;
          default: rand_coord = '0;
        endcase
      end
      default: rand_coord = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [63:0] pair(logic [31:0] lo, logic [31:0] hi);
    pair = {hi, lo};
  endfunction

  task automatic test_identity_extremes();
    logic [31:0] vals [6];
    vals = '{Q_MAX, Q_MIN, 32'h0, Q_ONE, Q_NEG_ONE, 32'h0000_0001};
    for (int i = 0; i < 6; i++) send_point(vals[i], vals[(i + 1) % 6], vals[(i + 3) % 6]);
    send_point(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // projection with w taken from z, zero w when z is zero, and clamping
  task automatic test_divide_cases();
    logic [63:0] m [CFG_NUM_REGS];
    m = '{pair(Q_ONE, 0), 0, pair(0, Q_ONE), 0, 0, pair(Q_ONE, Q_ONE), 0, 0};
    write_matrix(m);
    send_point(Q_ONE, Q_ONE, 32'h0);
    send_point(Q_MAX, Q_MIN, 32'h0000_0001);
    send_point(Q_MIN, Q_MAX, 32'hFFFF_FFFF);
    send_point(32'h0003_0000, 32'hFFFA_0000, 32'h0002_0000);
    send_point(32'h0003_0000, 32'hFFFA_0000, 32'hFFFE_0000);
    send_point(Q_MIN, Q_MIN, Q_NEG_ONE);
    // extreme entries everywhere
    m = '{pair(Q_MAX, Q_MIN), pair(Q_MIN, Q_MAX), pair(Q_MIN, Q_MIN), pair(Q_MAX, Q_MAX),
          pair(Q_MAX, Q_MAX), pair(Q_MIN, Q_MIN), pair(Q_MIN, Q_MAX), pair(Q_MAX, Q_MIN)};
    write_matrix(m);
    send_point(Q_MAX, Q_MAX, Q_MAX);
    send_point(Q_MIN, Q_MIN, Q_MIN);
    send_point(Q_MIN, Q_MAX, 32'h0);
  endtask

  // writes beyond the last register must change nothing
  task automatic test_unused_index();
    logic [63:0] m [CFG_NUM_REGS];
    for (int i = 0; i < CFG_NUM_REGS; i++) m[i] = matrix_copy[i];
    m[REG_ROW4_SECOND] = pair(32'h0002_0000, Q_ONE);
    write_matrix(m);
    write_reg(REG_FIRST_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_LAST_UNUSED, 64'h0);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    send_point(Q_ONE, 32'h0002_0000, Q_NEG_ONE);
    send_point(32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int n);
    logic [63:0] m [CFG_NUM_REGS];
    for (int k = 0; k < n; k++) begin
      if (k % 55 == 0) begin
        for (int i = 0; i < CFG_NUM_REGS; i++) m[i] = pair(rand_coord(), rand_coord());
        // mostly keep w near one so the divide stays in range
        if ($urandom_range(3) != 0) begin
          m[REG_ROW1_SECOND][63:32] = $urandom_range(0, 32'h400) - 32'h200;
          m[REG_ROW2_SECOND][63:32] = $urandom_range(0, 32'h400) - 32'h200;
          m[REG_ROW3_SECOND][63:32] = $urandom_range(0, 32'h400) - 32'h200;
          m[REG_ROW4_SECOND][63:32] = Q_ONE + $urandom_range(0, 32'h2_0000);
        end
        write_matrix(m);
        src_idle_pct = idle_pct;
        snk_stall_pct = stall_pct;
      end
      // every so often hold off until the pipeline is empty
      if (k % 97 == 50) drain();
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    for (int i = 0; i < CFG_NUM_REGS; i++) matrix_copy[i] = CFG_RESET[i];
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_identity_extremes();
    test_divide_cases();
    test_unused_index();
    test_random_phase(0, 0, 275);
    test_random_phase(85, 0, 275);
    test_random_phase(0, 85, 275);
    test_random_phase(31, 31, 275);
    drain();
    $display("covered %0d points, %0d with zero w, %0d clamped, %0d register writes",
             n_points, n_wzero, n_sat, n_cfg);
    $display("idling phases: none, sender, receiver and both");
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* point_transform_perspective.f */
+incdir+hdl
hdl/ptp_pkg.sv
hdl/ptp_stream_if.sv
hdl/ptp_mac.sv
hdl/ptp_div.sv
hdl/point_transform_perspective.sv
dv/tb_point_transform_perspective.sv
